FILE: src/shbi_pkg.sv
// Shared types and constants for the string hash bucket index block.
`default_nettype none

package shbi_pkg;

  // Configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  // Hash mode codes
  localparam logic MODE_ELF = 1'b0;
  localparam logic MODE_FNV = 1'b1;

  // Seeds and FNV prime
  localparam logic [31:0] ELF_SEED = 32'h0000_0000;
  localparam logic [31:0] FNV_SEED = 32'd2166136261;
  localparam logic [31:0] FNV_MULT = 32'd16777619;

  localparam logic [30:0] SIZE_RESET = 31'd53;

  // Remainder unit: one quotient bit per step
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } shbi_in_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [30:0] bucket_index;
  } shbi_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc;       // input transfer this cycle
    logic step;      // one remainder step
    logic out_load;  // load result register
  } shbi_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } shbi_st_t;

endpackage

`default_nettype wire

FILE: src/string_hash_bucket_index.sv
// Top level: streaming key hash (ELF/PJW or FNV-1a) with bucket index by modulo.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_data             | in
//   result  | out_valid, out_stall, out_data          | out
//   config  | cfg_we, cfg_idx, cfg_data               | in
//
// A byte that is not last is taken while idle and its hash update registered.
// A last byte stalls the input while the restoring remainder unit runs its 32 steps
// and then while the result register is loaded. That load, and so the stall, is
// held off for as long as an earlier result still waits in its register.
// Reset (synchronous, rst_n low) selects ELF/PJW, table size 53 and seed 0.
// A stalled result waits in its register; bytes are still taken meanwhile, and only
// the hand-off of the next key's result waits for it to clear.
`default_nettype none

module string_hash_bucket_index (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_idx,
  input  wire logic [30:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire shbi_pkg::shbi_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output shbi_pkg::shbi_out_t       out_data
);
  import shbi_pkg::*;

  shbi_cmd_t cmd;

  // Controller
  shbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath
  shbi_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // a last-byte transfer starts the remainder unit, which holds off input
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_byte |=> in_stall)
    else $error("input not stalled after last byte");

  // a new result only appears while input is held off
  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised outside remainder completion");

  // a result never appears from plain byte transfers
  a_no_result_mid_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_byte && !out_valid |=> !out_valid)
    else $error("result produced without a last byte");
`endif

endmodule

`default_nettype wire

FILE: src/shbi_ctrl.sv
// Controller: state machine sequencing byte transfers, remainder steps and result hand-off.
`default_nettype none

module shbi_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output shbi_pkg::shbi_cmd_t  cmd
);
  import shbi_pkg::*;

  shbi_st_t           st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    // result register drains on a transfer
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            st_nxt  = ST_DIV;
            cnt_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for a free result register
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/shbi_dpath.sv
// Datapath: configuration registers, running hash, restoring remainder unit, result register.
`default_nettype none

module shbi_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_idx,
  input  wire logic [30:0]          cfg_data,
  input  wire shbi_pkg::shbi_in_t   in_data,
  input  wire shbi_pkg::shbi_cmd_t  cmd,
  output shbi_pkg::shbi_out_t       out_data
);
  import shbi_pkg::*;

  logic        mode_r;
  logic [30:0] size_r;
  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  logic [31:0] elf_h;
  logic [31:0] fnv_h;
  logic [31:0] seed;

  logic [31:0] dvd_r;
  logic [31:0] rem_r;
  logic [30:0] dsr_r;
  logic [31:0] keep_r;
  logic [31:0] trial;
  logic [31:0] rem_nxt;

  shbi_out_t   out_r;

  assign seed = (mode_r == MODE_FNV) ? FNV_SEED : ELF_SEED;

  // ELF/PJW step: fold top nibble into bits 7..4, then clear it
  always_comb begin
    elf_h        = {hash_r[27:0], 4'h0} + {24'h0, in_data.key_byte};
    elf_h[7:4]   = elf_h[7:4] ^ elf_h[31:28];
    elf_h[31:28] = 4'h0;
  end

  // FNV-1a step, product truncated to 32 bits
  assign fnv_h    = (hash_r ^ {24'h0, in_data.key_byte}) * FNV_MULT;
  assign hash_nxt = (mode_r == MODE_FNV) ? fnv_h : elf_h;

  // Configuration and running hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ELF;
      size_r <= SIZE_RESET;
      hash_r <= ELF_SEED;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MODE) begin
        mode_r <= cfg_data[0];
        hash_r <= (cfg_data[0] == MODE_FNV) ? FNV_SEED : ELF_SEED;
      end else begin
        size_r <= cfg_data;
      end
    end else if (cmd.acc) begin
      hash_r <= in_data.last_byte ? seed : hash_nxt;
    end
  end

  // Restoring remainder step
  always_comb begin
    trial   = {rem_r[30:0], dvd_r[31]};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? trial - {1'b0, dsr_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && in_data.last_byte) begin
      dvd_r  <= hash_nxt;
      keep_r <= hash_nxt;
      rem_r  <= '0;
      dsr_r  <= size_r;
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // Result register; a zero table size gives bucket 0
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.hash_value   <= keep_r;
      out_r.bucket_index <= (dsr_r == '0) ? '0 : rem_r[30:0];
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire
